### sv/resampling_sample_voice_defines.svh
// ----------------------------------------------------------------------------
// resampling sample voice assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RESAMPLING_SAMPLE_VOICE_DEFINES_SVH
`define RESAMPLING_SAMPLE_VOICE_DEFINES_SVH

// pre implies post in the same cycle
`define RSV_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rsv check failed");

// pre implies post in the next cycle
`define RSV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rsv check failed");

`endif

### sv/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg
// types and codes shared by the sample playback voice modules
// ----------------------------------------------------------------------------
`default_nettype none

package rsv_pkg;

  // command codes
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_PLAY  = 3'd2;
  localparam logic [2:0] CMD_PAUSE = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SPEED_RATIO   = 2'd0;
  localparam logic [1:0] CFG_VOICE_GAIN    = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_LENGTH = 2'd3;

  // voice state codes
  localparam logic [1:0] VS_STOPPED = 2'd0;
  localparam logic [1:0] VS_PLAYING = 2'd1;
  localparam logic [1:0] VS_PAUSED  = 2'd2;

  localparam logic [1:0] CHAN_STEREO = 2'd2;

  // step divider: 24 bit ratio over a 9 bit sub-step count
  localparam int DIV_W   = 24;
  localparam int DIVS_W  = 9;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [20:0] SAT_MAX = 21'sd32767;
  localparam logic signed [20:0] SAT_MIN = -21'sd32767;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_WAIT,
    ST_RD_L,
    ST_RD_R,
    ST_CAP,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ADV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [11:0]        load_address;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         voice_state;
    logic               play_refused;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [16:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

### sv/resampling_sample_voice.sv
// ----------------------------------------------------------------------------
// resampling_sample_voice
// one sample playback voice with linear interpolation at a fixed-point speed
// ----------------------------------------------------------------------------
//  channel  ports                                 handshake
//  input    start, busy, in_data                  taken when start and !busy
//  result   out_strobe, out_data                  one cycle strobe, no stall
//  config   cfg_valid, cfg_ready, cfg_index/data  taken when valid and ready
//
//  load, play, pause, stop and an idle tick go to ST_DONE, which registers
//  the result strobe. a playing tick waits in ST_DIV_WAIT on the serial step
//  divider, then runs up to M = 2*max(floor(ratio),1) (up to 510) sub-steps
//  of ST_RD_L, ST_RD_R, ST_CAP, ST_ADV on the single store read port; the
//  first adds ST_M1, ST_M2, ST_M3 of the shared multiplier per mixed channel.
//  busy stays high until the result. reset is synchronous; the store needs
//  no clearing pass. STORE_WORDS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none
`include "resampling_sample_voice_defines.svh"

module resampling_sample_voice
  import rsv_pkg::*;
#(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_strobe,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int AW  = $clog2(STORE_WORDS);
  localparam int RXW = (AW > 14) ? AW : 14;
  localparam int WXW = (AW > 12) ? AW : 12;

  state_t state_r, state_nxt;

  logic [23:0] speed_r;
  logic [15:0] gain_r;
  logic [1:0]  chan_cnt_r;
  logic [12:0] len_r;

  logic               playing_r;
  logic [12:0]        frame_r;
  logic [15:0]        frac_r;
  logic [12:0]        prev_pos_r;
  logic signed [15:0] prev_left_r;
  logic signed [15:0] prev_right_r;

  logic [DIV_W-1:0]   step_r;
  logic [DIVS_W-1:0]  sub_cnt_r;
  logic               chan_sel_r;
  logic signed [15:0] cur_left_r;
  logic signed [15:0] cur_right_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic               refused_r;
  logic               out_strobe_r;
  out_item_t          out_data_r;

  logic accept_w;
  logic stereo_w;
  logic [7:0]        ip_w;
  logic [DIVS_W-1:0] mult_w;
  logic              last_w;

  logic [13:0]     base_w;
  logic [13:0]     base_p1_w;
  logic [RXW-1:0]  raddr_x;
  logic [WXW-1:0]  waddr_x;
  logic            store_we;
  logic [15:0]     rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  logic signed [48:0] prod;

  logic signed [15:0] cur_sel_w;
  logic signed [15:0] prev_sel_w;
  logic signed [16:0] diff_w;
  logic signed [33:0] lerp_w;
  logic signed [48:0] rnd_w;
  logic signed [20:0] r21_w;
  logic signed [15:0] sat_w;

  logic [23:0] acc_w;
  logic [13:0] newpos_w;
  logic        stop_w;

  assign accept_w = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign stereo_w = (chan_cnt_r == CHAN_STEREO);

  assign ip_w   = speed_r[23:16];
  assign mult_w = {((ip_w > 8'd1) ? ip_w : 8'd1), 1'b0};
  assign last_w = ((sub_cnt_r + 1'b1) == mult_w);

  // frame address, wraps modulo the store size
  assign base_w    = stereo_w ? {frame_r, 1'b0} : {1'b0, frame_r};
  assign base_p1_w = base_w + 14'd1;
  assign waddr_x   = WXW'(in_data.load_address);

  // interpolation arithmetic around the shared multiplier
  always_comb begin
    cur_sel_w  = chan_sel_r ? cur_right_r : cur_left_r;
    prev_sel_w = chan_sel_r ? prev_right_r : prev_left_r;
    diff_w     = {cur_sel_w[15], cur_sel_w} - {prev_sel_w[15], prev_sel_w};
    lerp_w     = prod[33:0] + {{2{prev_sel_w[15]}}, prev_sel_w, 16'd0};
    rnd_w      = prod + {21'd0, 1'b1, 27'd0};
    r21_w      = rnd_w[48:28];
    if (r21_w > SAT_MAX) begin
      sat_w = SAT_MAX[15:0];
    end else if (r21_w < SAT_MIN) begin
      sat_w = SAT_MIN[15:0];
    end else begin
      sat_w = r21_w[15:0];
    end
  end

  // position advance of one sub-step
  always_comb begin
    acc_w    = {8'd0, frac_r} + step_r;
    newpos_w = {1'b0, frame_r} + {6'd0, acc_w[23:16]};
    stop_w   = (newpos_w >= {1'b0, len_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_w) begin
          if (in_data.command == CMD_TICK && playing_r) begin
            state_nxt = ST_DIV_WAIT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_RD_L;
        end
      end
      ST_RD_L: state_nxt = ST_RD_R;
      ST_RD_R: state_nxt = ST_CAP;
      ST_CAP:  state_nxt = (sub_cnt_r == '0) ? ST_M1 : ST_ADV;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = (!chan_sel_r && stereo_w) ? ST_M1 : ST_ADV;
      ST_ADV:  state_nxt = (stop_w || last_w) ? ST_DONE : ST_RD_L;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    store_we         = 1'b0;
    raddr_x          = RXW'(base_w);
    div_req.start    = 1'b0;
    div_req.dividend = speed_r;
    div_req.divisor  = mult_w;
    mul_req.a        = '0;
    mul_req.b        = '0;
    unique case (state_r)
      ST_IDLE: begin
        store_we      = accept_w && (in_data.command == CMD_LOAD);
        div_req.start = accept_w && (in_data.command == CMD_TICK) && playing_r;
      end
      ST_RD_R: raddr_x = RXW'(base_p1_w);
      ST_M1: begin
        mul_req.a = {{15{diff_w[16]}}, diff_w};
        mul_req.b = {1'b0, frac_r};
      end
      ST_M2: begin
        mul_req.a = lerp_w[31:0];
        mul_req.b = {1'b0, gain_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r      <= 24'd65536;
      gain_r       <= 16'd4096;
      chan_cnt_r   <= CHAN_STEREO;
      len_r        <= '0;
      playing_r    <= 1'b0;
      frame_r      <= '0;
      frac_r       <= '0;
      prev_pos_r   <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPEED_RATIO:   speed_r    <= cfg_data;
          CFG_VOICE_GAIN:    gain_r     <= cfg_data[15:0];
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[1:0];
          CFG_SAMPLE_LENGTH: len_r      <= cfg_data[12:0];
          default: begin
          end
        endcase
      end

      out_strobe_r <= (state_r == ST_DONE);

      unique case (state_r)
        ST_IDLE: begin
          if (accept_w) begin
            left_r     <= '0;
            right_r    <= '0;
            refused_r  <= 1'b0;
            sub_cnt_r  <= '0;
            chan_sel_r <= 1'b0;
            unique case (in_data.command)
              CMD_PLAY: begin
                if (len_r == '0) begin
                  refused_r <= 1'b1;
                end else begin
                  playing_r <= 1'b1;
                end
              end
              CMD_PAUSE: playing_r <= 1'b0;
              CMD_STOP: begin
                playing_r <= 1'b0;
                frame_r   <= '0;
                frac_r    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            step_r <= div_rsp.quotient;
          end
        end
        ST_RD_R: cur_left_r <= rdata;
        ST_CAP:  cur_right_r <= stereo_w ? rdata : cur_left_r;
        ST_M3: begin
          if (!chan_sel_r) begin
            left_r <= sat_w;
            if (!stereo_w) begin
              right_r <= sat_w;
            end
            chan_sel_r <= 1'b1;
          end else begin
            right_r <= sat_w;
          end
        end
        ST_ADV: begin
          sub_cnt_r <= sub_cnt_r + 1'b1;
          if (newpos_w != {1'b0, prev_pos_r}) begin
            prev_pos_r   <= newpos_w[12:0];
            prev_left_r  <= cur_left_r;
            prev_right_r <= cur_right_r;
          end
          if (stop_w) begin
            playing_r <= 1'b0;
            frame_r   <= '0;
            frac_r    <= '0;
          end else begin
            frame_r <= newpos_w[12:0];
            frac_r  <= acc_w[15:0];
          end
        end
        ST_DONE: begin
          out_data_r.left_sample  <= left_r;
          out_data_r.right_sample <= right_r;
          out_data_r.play_refused <= refused_r;
          if (playing_r) begin
            out_data_r.voice_state <= VS_PLAYING;
          end else if (frame_r == '0) begin
            out_data_r.voice_state <= VS_STOPPED;
          end else begin
            out_data_r.voice_state <= VS_PAUSED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  rsv_store #(
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr_x[AW-1:0]),
    .wdata (in_data.load_value),
    .raddr (raddr_x[AW-1:0]),
    .rdata (rdata)
  );

  rsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rsv_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // a result strobe never repeats back to back
  `RSV_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  // a non-tick item always gives its result through ST_DONE and the registered strobe
  `RSV_ASSERT_NEXT(a_cmd_result, accept_w && (in_data.command != CMD_TICK), ##1 out_strobe)
  // the divider only finishes while the sequencer waits for it
  `RSV_ASSERT_SAME(a_div_done, div_rsp.done, state_r == ST_DIV_WAIT)
  // sub-steps only run while the voice plays
  `RSV_ASSERT_SAME(a_loop_playing, state_r == ST_RD_L, playing_r)

endmodule

`default_nettype wire

### sv/rsv_store.sv
// ----------------------------------------------------------------------------
// rsv_store
// sample word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rsv_store #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/rsv_div.sv
// ----------------------------------------------------------------------------
// rsv_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rsv_div
  import rsv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIV_W-1:0]     quo_r;

  logic [DIVS_W:0]      shift_w;
  logic [DIVS_W:0]      diff_w;
  logic                 ge_w;
  logic [DIVS_W-1:0]    rem_nxt;

  always_comb begin
    shift_w = {rem_r, quo_r[DIV_W-1]};
    diff_w  = shift_w - {1'b0, dvs_r};
    ge_w    = (shift_w >= {1'b0, dvs_r});
    rem_nxt = ge_w ? diff_w[DIVS_W-1:0] : shift_w[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], ge_w};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

### sv/rsv_mul.sv
// ----------------------------------------------------------------------------
// rsv_mul
// shared signed multiplier, 32 by 17 bits, registered product
// ----------------------------------------------------------------------------
`default_nettype none

module rsv_mul
  import rsv_pkg::*;
(
  input  wire logic     clk,
  input  wire mul_req_t req,
  output logic signed [48:0] prod
);

  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
  end

endmodule

`default_nettype wire
